// ===== design/ifps_pkg.sv =====
// Shared constants and widths for the IMU FIFO poll supervisor.
`default_nettype none
package ifps_pkg;

  // Stream payload widths (whole bytes)
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 80;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  // Field widths
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned DELAY_W  = 20;
  localparam int unsigned SAMP_W   = 6;
  localparam int unsigned REGCNT_W = 4;
  localparam int unsigned REGIDX_W = 3;
  localparam int unsigned FAIL_W   = 4;
  localparam int unsigned ERR_W    = 32;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FIFO_SAMPLES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL_US  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECKED_REG_COUNT = 2'd2;

  // Register reset values
  localparam logic [SAMP_W-1:0]   MAX_FIFO_RESET  = 6'd32;
  localparam logic [DELAY_W-1:0]  POLL_RESET      = 20'd1250;
  localparam logic [REGCNT_W-1:0] REG_COUNT_RESET = 4'd7;

  // Timing constants in microseconds
  localparam int unsigned T_1000MS = 1000000;
  localparam int unsigned T_150MS  = 150000;
  localparam int unsigned T_100MS  = 100000;
  localparam int unsigned T_20MS   = 20000;
  localparam int unsigned T_10MS   = 10000;

  localparam int unsigned FAIL_LIMIT = 10;
  localparam int unsigned REG_COUNT_MAX = 8;

  // FIFO event codes
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_OVERFLOW = 2'd1;
  localparam logic [1:0] EV_EMPTY    = 2'd2;
  localparam logic [1:0] EV_DATA     = 2'd3;

endpackage
`default_nettype wire

// ===== design/imu_fifo_poll_supervisor.sv =====
// Top level of the IMU FIFO poll supervisor: mode sequencing and per-run decisions.
`default_nettype none
// One transfer on the in_ stream is one scheduler run: the current time and the
// outcomes of the bus operations done outside this block. For each run the block
// returns exactly one result transfer on the out_ stream: next mode, actions to
// issue (boot, FIFO reset, burst read length, register check, temperature and
// magnetometer update), FIFO event, delay to the next run, the failure counter
// and the saturating error count. A run passes through an input register and a
// result register with the decision logic between them; the result register loads
// when the held run is processed and holds its result until it transfers. One
// run is taken every cycle as long as the result side keeps draining; throughput
// is set by that single-pass stage, which also updates the mode, timestamps and
// counters. The cfg_ port writes
// max_fifo_samples (index 0), poll_interval_us (1) and checked_reg_count (2);
// write it only while no run is in flight. Out-of-range poll interval and
// register count values are clamped at use, not at write.
module imu_fifo_poll_supervisor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata, lowest bit up: now_us[63:0], ident_ok, setup_ok, fifo_status[7:0],
  // read_ok, check_ok, zero fill
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [ifps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata, lowest bit up: next_mode[1:0], issue_boot, issue_fifo_reset,
  // read_count[5:0], check_valid, check_index[2:0], update_temp_mag,
  // fifo_event[1:0], delay_us[19:0], periodic, failures[3:0],
  // error_count[31:0], zero fill
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [ifps_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                             cfg_wr_en,
  input  wire logic [ifps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ifps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ifps_pkg::*;

  typedef enum logic [1:0] {
    MODE_RESET  = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_CONFIG = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // Configuration registers
  logic [SAMP_W-1:0]   max_fifo_r;
  logic [DELAY_W-1:0]  poll_r;
  logic [REGCNT_W-1:0] reg_count_r;

  // Supervisor state
  mode_t               mode_r, mode_nxt;
  logic [TIME_W-1:0]   reset_time_r, reset_time_nxt;
  logic [TIME_W-1:0]   check_time_r, check_time_nxt;
  logic [TIME_W-1:0]   temp_time_r, temp_time_nxt;
  logic [FAIL_W-1:0]   fail_r, fail_nxt;
  logic [REGIDX_W-1:0] ptr_r, ptr_nxt;
  logic [ERR_W-1:0]    err_r, err_nxt;

  // Stream stages
  logic                   in_v_r;
  logic [IN_TDATA_W-1:0]  in_data_r;
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   adv;

  // Unpacked run fields
  logic [TIME_W-1:0] now;
  logic              ident_ok, setup_ok, read_ok, check_ok;
  logic [7:0]        fifo_status;
  logic [4:0]        level;

  // Result fields
  logic                boot, fifo_rst, cv, upd, per;
  logic [SAMP_W-1:0]   rd;
  logic [REGIDX_W-1:0] ci;
  logic [1:0]          ev;
  logic [DELAY_W-1:0]  delay;

  // Helpers
  logic [TIME_W-1:0]   since_reset, since_check, since_temp;
  logic                reset_expired;
  logic [DELAY_W-1:0]  interval_eff;
  logic [REGCNT_W-1:0] count_eff;
  logic [REGIDX_W-1:0] ptr_use;
  logic [REGCNT_W-1:0] ptr_inc;
  logic                ok, forced;
  logic [1:0]          err_add;
  logic [ERR_W+1:0]    err_sum;
  logic [FAIL_W-1:0]   fail_step;

  assign now         = in_data_r[63:0];
  assign ident_ok    = in_data_r[64];
  assign setup_ok    = in_data_r[65];
  assign fifo_status = in_data_r[73:66];
  assign read_ok     = in_data_r[74];
  assign check_ok    = in_data_r[75];
  assign level       = fifo_status[4:0];

  // Process the held run whenever the result register is free or draining
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  assign since_reset   = now - reset_time_r;
  assign since_check   = now - check_time_r;
  assign since_temp    = now - temp_time_r;
  assign reset_expired = since_reset > TIME_W'(T_1000MS);

  // Clamp configuration values at use
  always_comb begin
    if (poll_r == '0) begin
      interval_eff = DELAY_W'(1);
    end else if (poll_r > DELAY_W'(T_1000MS)) begin
      interval_eff = DELAY_W'(T_1000MS);
    end else begin
      interval_eff = poll_r;
    end
    if (reg_count_r == '0) begin
      count_eff = REGCNT_W'(1);
    end else if (reg_count_r > REGCNT_W'(REG_COUNT_MAX)) begin
      count_eff = REGCNT_W'(REG_COUNT_MAX);
    end else begin
      count_eff = reg_count_r;
    end
  end

  // Stale pointer falls back to register 0
  assign ptr_use = ({1'b0, ptr_r} < count_eff) ? ptr_r : '0;
  assign ptr_inc = {1'b0, ptr_use} + REGCNT_W'(1);

  assign fail_step = (fail_r == '1) ? fail_r : fail_r + FAIL_W'(1);

  always_comb begin
    mode_nxt       = mode_r;
    reset_time_nxt = reset_time_r;
    check_time_nxt = check_time_r;
    temp_time_nxt  = temp_time_r;
    fail_nxt       = fail_r;
    ptr_nxt        = ptr_r;
    boot           = 1'b0;
    fifo_rst       = 1'b0;
    rd             = '0;
    cv             = 1'b0;
    ci             = '0;
    upd            = 1'b0;
    ev             = EV_NONE;
    delay          = '0;
    per            = 1'b0;
    ok             = 1'b0;
    forced         = 1'b0;
    err_add        = 2'd0;

    unique case (mode_r)
      MODE_RESET: begin
        boot           = 1'b1;
        reset_time_nxt = now;
        fail_nxt       = '0;
        mode_nxt       = MODE_WAIT;
        delay          = DELAY_W'(T_150MS);
      end
      MODE_WAIT: begin
        if (ident_ok) begin
          mode_nxt = MODE_CONFIG;
          delay    = DELAY_W'(T_10MS);
        end else if (reset_expired) begin
          mode_nxt = MODE_RESET;
          delay    = DELAY_W'(T_100MS);
        end else begin
          delay = DELAY_W'(T_10MS);
        end
      end
      MODE_CONFIG: begin
        if (setup_ok) begin
          mode_nxt = MODE_READ;
          per      = 1'b1;
          delay    = interval_eff;
          fifo_rst = 1'b1;
        end else begin
          if (reset_expired) begin
            mode_nxt = MODE_RESET;
          end
          delay = DELAY_W'(T_100MS);
        end
      end
      MODE_READ: begin
        // Classify the FIFO status: overflow wins over empty
        if (fifo_status[6] || ({1'b0, level} > max_fifo_r)) begin
          ev       = EV_OVERFLOW;
          err_add  = 2'd1;
          fifo_rst = 1'b1;
        end else if (fifo_status[5] || level == '0) begin
          ev      = EV_EMPTY;
          err_add = 2'd1;
        end else begin
          ev = EV_DATA;
          rd = {1'b0, level};
          if (read_ok) begin
            ok = 1'b1;
          end else begin
            err_add = 2'd1;
          end
        end

        if (ok) begin
          if (fail_r != '0) begin
            fail_nxt = fail_r - FAIL_W'(1);
          end
        end else begin
          fail_nxt = fail_step;
          forced   = fail_step > FAIL_W'(FAIL_LIMIT);
        end

        if (!forced) begin
          if (!ok || since_check > TIME_W'(T_100MS)) begin
            cv = 1'b1;
            ci = ptr_use;
            if (check_ok) begin
              check_time_nxt = now;
              ptr_nxt = (ptr_inc >= count_eff) ? '0 : ptr_inc[REGIDX_W-1:0];
            end else begin
              err_add = err_add + 2'd1;
              forced  = 1'b1;
            end
          end else if (now >= temp_time_r && since_temp >= TIME_W'(T_20MS)) begin
            upd           = 1'b1;
            temp_time_nxt = now;
          end
        end

        if (forced) begin
          mode_nxt = MODE_RESET;
        end else begin
          per   = 1'b1;
          delay = interval_eff;
        end
      end
    endcase
  end

  // Saturating error total; at most two events per run
  assign err_sum = {2'b00, err_r} + (ERR_W+2)'(err_add);
  assign err_nxt = (err_sum > {2'b00, {ERR_W{1'b1}}}) ? {ERR_W{1'b1}} : err_sum[ERR_W-1:0];

  assign out_data_nxt = {6'd0, err_nxt, fail_nxt, per, delay, ev, upd, ci, cv, rd,
                         fifo_rst, boot, mode_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      max_fifo_r   <= MAX_FIFO_RESET;
      poll_r       <= POLL_RESET;
      reg_count_r  <= REG_COUNT_RESET;
      mode_r       <= MODE_RESET;
      reset_time_r <= '0;
      check_time_r <= '0;
      temp_time_r  <= '0;
      fail_r       <= '0;
      ptr_r        <= '0;
      err_r        <= '0;
    end else begin
      // Input stage: load on transfer, hold while the run waits
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      // Result stage: advance on a processed run, drop after transfer
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (adv) begin
        mode_r       <= mode_nxt;
        reset_time_r <= reset_time_nxt;
        check_time_r <= check_time_nxt;
        temp_time_r  <= temp_time_nxt;
        fail_r       <= fail_nxt;
        ptr_r        <= ptr_nxt;
        err_r        <= err_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_MAX_FIFO_SAMPLES:  max_fifo_r  <= cfg_wdata[SAMP_W-1:0];
          CFG_POLL_INTERVAL_US:  poll_r      <= cfg_wdata[DELAY_W-1:0];
          CFG_CHECKED_REG_COUNT: reg_count_r <= cfg_wdata[REGCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/ifps_checker.sv =====
// Checker for the FIFO poll supervisor: predicts each run's decision and compares results.
module ifps_checker import ifps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     pending
);

  typedef enum logic [1:0] {
    MODE_RESET, MODE_WAIT_RESET, MODE_CONFIGURE, MODE_FIFO_READ
  } sup_mode_e;

  // Result layout, last member in the lowest bits
  typedef struct packed {
    logic [ERR_W-1:0]    error_count;
    logic [FAIL_W-1:0]   failures;
    logic                periodic;
    logic [DELAY_W-1:0]  delay_us;
    logic [1:0]          fifo_event;
    logic                update_temp_mag;
    logic [REGIDX_W-1:0] check_index;
    logic                check_valid;
    logic [SAMP_W-1:0]   read_count;
    logic                issue_fifo_reset;
    logic                issue_boot;
    logic [1:0]          next_mode;
  } run_decision_t;

  localparam logic [TIME_W-1:0]  BOOT_TIMEOUT_US = 64'(T_1000MS);
  localparam logic [TIME_W-1:0]  CHECK_PERIOD_US = 64'(T_100MS);
  localparam logic [TIME_W-1:0]  TEMP_PERIOD_US  = 64'(T_20MS);
  localparam logic [DELAY_W-1:0] BOOT_WAIT_US    = 20'(T_150MS);
  localparam logic [DELAY_W-1:0] RETRY_US        = 20'(T_100MS);
  localparam logic [DELAY_W-1:0] IDENT_POLL_US   = 20'(T_10MS);
  localparam logic [DELAY_W-1:0] MAX_POLL_US     = 20'(T_1000MS);

  // Configuration copy
  logic [SAMP_W-1:0]   max_samples;
  logic [DELAY_W-1:0]  poll_us;
  logic [REGCNT_W-1:0] reg_count;

  // Supervisor state copy
  sup_mode_e           mode;
  logic [TIME_W-1:0]   reset_time;
  logic [TIME_W-1:0]   last_check_time;
  logic [TIME_W-1:0]   last_temp_time;
  logic [FAIL_W-1:0]   fail_cnt;
  logic [REGIDX_W-1:0] chk_ptr;
  logic [ERR_W-1:0]    err_total;

  run_decision_t pending_decisions[$];
  run_decision_t want;

  function automatic void bump_errors();
    if (err_total != '1) err_total = err_total + 1'b1;
  endfunction

  function automatic logic [DELAY_W-1:0] poll_period();
    if (poll_us == '0) return 20'd1;
    if (poll_us > MAX_POLL_US) return MAX_POLL_US;
    return poll_us;
  endfunction

  function automatic run_decision_t decide_run(input logic [IN_TDATA_W-1:0] run);
    logic [TIME_W-1:0] now;
    logic              ident_ok, setup_ok, read_ok, check_ok;
    logic [7:0]        status;
    logic [4:0]        level;
    logic              good, forced;
    logic [3:0]        cnt, p;
    run_decision_t     r;
    now      = run[63:0];
    ident_ok = run[64];
    setup_ok = run[65];
    status   = run[73:66];
    read_ok  = run[74];
    check_ok = run[75];
    level    = status[4:0];
    good     = 1'b0;
    forced   = 1'b0;
    r        = '0;
    case (mode)
      MODE_RESET: begin
        r.issue_boot = 1'b1;
        reset_time   = now;
        fail_cnt     = '0;
        mode         = MODE_WAIT_RESET;
        r.delay_us   = BOOT_WAIT_US;
      end
      MODE_WAIT_RESET: begin
        if (ident_ok) begin
          mode       = MODE_CONFIGURE;
          r.delay_us = IDENT_POLL_US;
        end else if (now - reset_time > BOOT_TIMEOUT_US) begin
          mode       = MODE_RESET;
          r.delay_us = RETRY_US;
        end else begin
          r.delay_us = IDENT_POLL_US;
        end
      end
      MODE_CONFIGURE: begin
        if (setup_ok) begin
          mode               = MODE_FIFO_READ;
          r.periodic         = 1'b1;
          r.delay_us         = poll_period();
          r.issue_fifo_reset = 1'b1;
        end else begin
          if (now - reset_time > BOOT_TIMEOUT_US) mode = MODE_RESET;
          r.delay_us = RETRY_US;
        end
      end
      default: begin
        // Classify the FIFO source byte: overrun wins over empty
        if (status[6] || {1'b0, level} > max_samples) begin
          r.fifo_event       = EV_OVERFLOW;
          r.issue_fifo_reset = 1'b1;
          bump_errors();
        end else if (status[5] || level == '0) begin
          r.fifo_event = EV_EMPTY;
          bump_errors();
        end else begin
          r.fifo_event = EV_DATA;
          r.read_count = {1'b0, level};
          if (read_ok) begin
            good = 1'b1;
            if (fail_cnt != '0) fail_cnt = fail_cnt - 1'b1;
          end else begin
            bump_errors();
          end
        end
        if (!good) begin
          if (fail_cnt != 4'd15) fail_cnt = fail_cnt + 1'b1;
          if (fail_cnt > 4'(FAIL_LIMIT)) forced = 1'b1;
        end
        if (!forced) begin
          if (!good || now - last_check_time > CHECK_PERIOD_US) begin
            // Clamp the rotation length, restart a stale pointer at zero
            cnt = (reg_count == '0) ? 4'd1 :
                  (reg_count > 4'(REG_COUNT_MAX)) ? 4'(REG_COUNT_MAX) : reg_count;
            p = ({1'b0, chk_ptr} < cnt) ? {1'b0, chk_ptr} : 4'd0;
            r.check_valid = 1'b1;
            r.check_index = p[2:0];
            if (check_ok) begin
              last_check_time = now;
              chk_ptr = (p + 4'd1 >= cnt) ? 3'd0 : 3'(p + 4'd1);
            end else begin
              bump_errors();
              forced = 1'b1;
            end
          end else if (now >= last_temp_time && now - last_temp_time >= TEMP_PERIOD_US) begin
            r.update_temp_mag = 1'b1;
            last_temp_time    = now;
          end
        end
        if (forced) begin
          mode = MODE_RESET;
        end else begin
          r.periodic = 1'b1;
          r.delay_us = poll_period();
        end
      end
    endcase
    r.next_mode   = mode;
    r.failures    = fail_cnt;
    r.error_count = err_total;
    return r;
  endfunction

  task automatic show_decision(input string tag, input run_decision_t r);
    $display("  %s mode=%0d boot=%0b frst=%0b rd=%0d chk=%0b/%0d temp=%0b ev=%0d",
             tag, r.next_mode, r.issue_boot, r.issue_fifo_reset, r.read_count,
             r.check_valid, r.check_index, r.update_temp_mag, r.fifo_event);
    $display("  %s delay=%0d per=%0b fail=%0d err=%0d",
             tag, r.delay_us, r.periodic, r.failures, r.error_count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      max_samples     = MAX_FIFO_RESET;
      poll_us         = POLL_RESET;
      reg_count       = REG_COUNT_RESET;
      mode            = MODE_RESET;
      reset_time      = '0;
      last_check_time = '0;
      last_temp_time  = '0;
      fail_cnt        = '0;
      chk_ptr         = '0;
      err_total       = '0;
      mismatches      = 0;
      pending_decisions.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAX_FIFO_SAMPLES:  max_samples = cfg_wdata[SAMP_W-1:0];
          CFG_POLL_INTERVAL_US:  poll_us     = cfg_wdata;
          CFG_CHECKED_REG_COUNT: reg_count   = cfg_wdata[REGCNT_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pending_decisions.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h at %0t", out_tdata, $time);
          mismatches++;
        end else begin
          want = pending_decisions.pop_front();
          if (OUT_TDATA_W'(want) !== out_tdata) begin
            if (mismatches < 10) begin
              $display("result mismatch at %0t", $time);
              show_decision("exp", want);
              show_decision("got", run_decision_t'(out_tdata[$bits(run_decision_t)-1:0]));
              $display("  raw exp=%h got=%h", OUT_TDATA_W'(want), out_tdata);
            end
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) pending_decisions.push_back(decide_run(in_tdata));
      pending <= pending_decisions.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the FIFO poll supervisor testbench: clock, reset, run stimulus and verdict.
module tb;
  import ifps_pkg::*;

  // Run budget and the long result-side hold-off
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_RUNS  = 125;
  // Index 3 decodes to no register; writing it must change nothing
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // in_tdata, lowest bit up: now_us[63:0], ident_ok, setup_ok, fifo_status[7:0],
  // read_ok, check_ok, zero fill
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata, lowest bit up: next_mode[1:0], issue_boot, issue_fifo_reset,
  // read_count[5:0], check_valid, check_index[2:0], update_temp_mag,
  // fifo_event[1:0], delay_us[19:0], periodic, failures[3:0],
  // error_count[31:0], zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int pending;

  // Stimulus knobs, changed only between phases, and the running scheduler time
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          read_ok_pct = 92;
  logic [5:0]  max_cfg = MAX_FIFO_RESET;
  logic [63:0] sim_now_us = '0;

  // Toggle hold_req to start one long hold-off on the result side
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;

  imu_fifo_poll_supervisor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  ifps_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a run that hangs: a lost result or a stuck handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, plus a counted hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_seen  <= hold_req;
    end else begin
      hold_seen <= hold_req;
      if (hold_req != hold_seen) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_run(input logic [63:0] now,
                                                     input logic ident_ok,
                                                     input logic setup_ok,
                                                     input logic [7:0] status,
                                                     input logic read_ok,
                                                     input logic check_ok);
    return {4'b0, check_ok, read_ok, status, setup_ok, ident_ok, now};
  endfunction

  // Advance the scheduler clock and draw the outcomes of one run
  function automatic logic [IN_TDATA_W-1:0] next_scheduler_run();
    int         pick;
    int         lim;
    logic [7:0] status;
    pick = $urandom_range(99);
    if (pick < 2) begin
      // jump anywhere, which also moves every time bit
      sim_now_us = {$urandom, $urandom};
    end else if (pick < 5) begin
      sim_now_us = sim_now_us - 64'($urandom_range(50000));
    end else if (pick < 10) begin
      // long gap: 0.9 s to 1.3 s, which can trip the boot timeout
      sim_now_us = sim_now_us + 64'($urandom_range(1300000, 900000));
    end else begin
      sim_now_us = sim_now_us + 64'($urandom_range(30000));
    end
    lim = (max_cfg == '0) ? 1 : (max_cfg > 6'd31) ? 31 : int'(max_cfg);
    // mostly a plausible level with clean flags, else a raw byte
    if ($urandom_range(99) < 80) begin
      status = {1'($urandom), 2'b00, 5'($urandom_range(lim, 1))};
    end else begin
      status = 8'($urandom);
    end
    return pack_run(sim_now_us, $urandom_range(99) < 60, $urandom_range(99) < 60, status,
                    $urandom_range(99) < read_ok_pct, $urandom_range(99) < 97);
  endfunction

  // Offer one run and hold it until the transfer happens
  task automatic send_run(input logic [IN_TDATA_W-1:0] run);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= run;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] max_s, input logic [19:0] poll,
                            input logic [3:0] regs);
    write_reg(CFG_MAX_FIFO_SAMPLES, 20'(max_s));
    write_reg(CFG_POLL_INTERVAL_US, poll);
    write_reg(CFG_CHECKED_REG_COUNT, 20'(regs));
    cfg_wr_en <= 1'b0;
    max_cfg = max_s;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: walk every mode, both timeouts, each FIFO event and a forced reset
    send_run(pack_run(64'd0,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd150000,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd1200000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd1300000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd1310000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd1320000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd2400000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd2500000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd2510000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd2520000, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd2521250, 1'b0, 1'b0, 8'h45, 1'b1, 1'b1));
    send_run(pack_run(64'd2522500, 1'b0, 1'b0, 8'h20, 1'b1, 1'b1));
    send_run(pack_run(64'd2523750, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1));
    send_run(pack_run(64'd2525000, 1'b0, 1'b0, 8'h1F, 1'b1, 1'b1));
    send_run(pack_run(64'd2526250, 1'b0, 1'b0, 8'h1F, 1'b0, 1'b1));
    send_run(pack_run(64'd2550000, 1'b0, 1'b0, 8'h05, 1'b1, 1'b1));
    send_run(pack_run(64'd2551250, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b1));
    send_run(pack_run(64'd2700000, 1'b0, 1'b0, 8'h9F, 1'b1, 1'b1));
    // time steps backwards: elapsed wraps large, temperature is not due
    send_run(pack_run(64'd2600000, 1'b0, 1'b0, 8'h0A, 1'b1, 1'b1));
    // failed read, then a failed register check forces a reset
    send_run(pack_run(64'd2601250, 1'b0, 1'b0, 8'h03, 1'b0, 1'b0));
    // reset near the top of the time range, then wrap past zero
    send_run(pack_run(64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd5,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd10, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    send_run(pack_run(64'd20, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    sim_now_us = 64'd20;

    // Random phases: each one drains, reconfigures, then streams runs
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: set_config(6'd32, 20'd1250, 4'd7);
        1: set_config(6'd0, 20'd0, 4'd0);
        2: set_config(6'd63, 20'hFFFFF, 4'd15);
        3: begin
          write_reg(CFG_UNUSED_INDEX, 20'($urandom));
          set_config(6'd1, 20'd1, 4'd1);
        end
        4: set_config(6'd31, 20'(T_1000MS), 4'(REG_COUNT_MAX));
        6: set_config(6'd16, 20'd999999, 4'd9);
        default: set_config(6'($urandom), 20'($urandom_range(T_1000MS, 1)), 4'($urandom));
      endcase
      // idle mix rotates: none, sender only, receiver only, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 56; end
        default: begin send_idle_pct = 29; recv_stall_pct <= 29; end
      endcase
      // odd phases fail most reads to drive the failure counter past its limit
      read_ok_pct = (ph % 2 == 1) ? 30 : 92;
      // back-pressure: hold the result side while runs keep coming
      if (ph == 0) hold_req <= ~hold_req;
      repeat (PHASE_RUNS) send_run(next_scheduler_run());
    end

    wait_drained();
    // let any stray result surface before the verdict
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ifps_pkg.sv
design/imu_fifo_poll_supervisor.sv
tb/ifps_checker.sv
tb/tb.sv
